FILE: rtl/mpbm_pkg.sv
// shared types and constants of the multi-pattern byte matcher
`default_nettype none

package mpbm_pkg;

	// trie geometry, settled by the 12-bit node index fields
	localparam int NODES  = 4096;
	localparam int NODE_W = $clog2(NODES);
	localparam int CNT_W  = 9;
	localparam int HOP_W  = $clog2(NODES + 1);
	localparam int CHAR_W = 8;
	localparam int KW_W   = 10;

	// command codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCAN  = 1'b1;

	// one command request
	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_index;
		logic [CHAR_W-1:0] node_char;
		logic [NODE_W-1:0] first_child;
		logic [CNT_W-1:0]  child_count;
		logic [NODE_W-1:0] fail_node;
		logic              ends_keyword;
		logic [KW_W-1:0]   keyword_number;
		logic [CHAR_W-1:0] text_byte;
		logic              text_start;
	} cmd_req_t;

	// one result request
	typedef struct packed {
		logic [KW_W-1:0] matched_keyword;
	} res_req_t;

	// node memory entry, the edge byte lives in a memory of its own
	typedef struct packed {
		logic [NODE_W-1:0] first_child;
		logic [CNT_W-1:0]  child_count;
		logic [NODE_W-1:0] fail_node;
		logic              ends_keyword;
		logic [KW_W-1:0]   keyword_number;
	} node_entry_t;

	// walker to output stage
	typedef struct packed {
		logic            valid;
		logic [KW_W-1:0] keyword;
	} walk_res_t;

	// walker sequencer states
	typedef enum logic [1:0] {
		WS_IDLE,
		WS_NODE,
		WS_EDGE,
		WS_FINAL
	} walk_state_t;

endpackage

`default_nettype wire

FILE: rtl/mpbm_cmd_if.sv
// command channel: node loads and text bytes
`default_nettype none

interface mpbm_cmd_if import mpbm_pkg::*; ();
	logic     valid;
	logic     ready;
	cmd_req_t req;

	modport source (output valid, output req, input ready);
	modport sink (input valid, input req, output ready);
endinterface

`default_nettype wire

FILE: rtl/mpbm_res_if.sv
// result channel: matched keyword ids
`default_nettype none

interface mpbm_res_if import mpbm_pkg::*; ();
	logic     valid;
	logic     ready;
	res_req_t req;

	modport source (output valid, output req, input ready);
	modport sink (input valid, input req, output ready);
endinterface

`default_nettype wire

FILE: rtl/mpbm_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module mpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mpbm_walker.sv
// trie walk sequencer: child search, failure hops and node loads
`default_nettype none

module mpbm_walker import mpbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mpbm_cmd_if.sink          cmd,
	// node memory
	output logic              node_we,
	output logic [NODE_W-1:0] node_waddr,
	output node_entry_t       node_wdata,
	output logic              node_re,
	output logic [NODE_W-1:0] node_raddr,
	input  node_entry_t       node_rd,
	// edge byte memory
	output logic              edge_we,
	output logic [NODE_W-1:0] edge_waddr,
	output logic [CHAR_W-1:0] edge_wdata,
	output logic              edge_re,
	output logic [NODE_W-1:0] edge_raddr,
	input  logic [CHAR_W-1:0] edge_rd,
	// result towards the output register
	output walk_res_t         res,
	input  logic              res_ready
);

	walk_state_t       state_q, state_d;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] node_q;
	logic [CHAR_W-1:0] ch_q;
	logic [CNT_W-1:0]  k_q;
	logic [HOP_W-1:0]  hops_q;

	logic              accept;
	logic              scan_accept;
	logic [NODE_W-1:0] start_node;
	logic [NODE_W-1:0] child_idx;
	logic [NODE_W-1:0] next_child_idx;
	logic              edge_hit;
	logic              last_child;
	logic              no_children;
	logic              miss_now;
	logic              miss_final;
	logic [NODE_W-1:0] miss_node;
	logic              final_done;

	// walk conditions
	always_comb begin
		accept         = cmd.valid && cmd.ready;
		scan_accept    = accept && (cmd.req.opcode == OP_SCAN);
		start_node     = cmd.req.text_start ? '0 : cur_q;
		child_idx      = node_rd.first_child + NODE_W'(k_q);
		next_child_idx = node_rd.first_child + NODE_W'(k_q + CNT_W'(1));
		edge_hit       = (edge_rd == ch_q);
		no_children    = (node_rd.child_count == '0);
		last_child     = (k_q == node_rd.child_count - CNT_W'(1));
		miss_now       = ((state_q == WS_NODE) && no_children) ||
		                 ((state_q == WS_EDGE) && !edge_hit && last_child);
		// root tried, or the hop budget spent: end on the root
		miss_final     = (node_q == '0) || (hops_q == HOP_W'(NODES));
		miss_node      = miss_final ? '0 : node_rd.fail_node;
		final_done     = !node_rd.ends_keyword || res_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WS_IDLE: begin
				if (scan_accept) begin
					state_d = WS_NODE;
				end
			end
			WS_NODE: begin
				if (no_children) begin
					state_d = miss_final ? WS_FINAL : WS_NODE;
				end else begin
					state_d = WS_EDGE;
				end
			end
			WS_EDGE: begin
				if (edge_hit) begin
					state_d = WS_FINAL;
				end else if (last_child) begin
					state_d = miss_final ? WS_FINAL : WS_NODE;
				end
			end
			WS_FINAL: begin
				if (final_done) begin
					state_d = WS_IDLE;
				end
			end
			default: state_d = WS_IDLE;
		endcase
	end

	// memory controls and result
	always_comb begin
		cmd.ready  = (state_q == WS_IDLE);
		node_we    = accept && (cmd.req.opcode == OP_WRITE);
		node_waddr = cmd.req.node_index;
		node_wdata = '{
			first_child:    cmd.req.first_child,
			child_count:    cmd.req.child_count,
			fail_node:      cmd.req.fail_node,
			ends_keyword:   cmd.req.ends_keyword,
			keyword_number: cmd.req.keyword_number
		};
		edge_we    = node_we;
		edge_waddr = cmd.req.node_index;
		edge_wdata = cmd.req.node_char;
		node_re    = 1'b0;
		node_raddr = '0;
		edge_re    = 1'b0;
		edge_raddr = '0;
		res        = '{valid: 1'b0, keyword: node_rd.keyword_number};
		unique case (state_q)
			WS_IDLE: begin
				node_re    = scan_accept;
				node_raddr = start_node;
			end
			WS_NODE: begin
				if (no_children) begin
					node_re    = 1'b1;
					node_raddr = miss_node;
				end else begin
					edge_re    = 1'b1;
					edge_raddr = node_rd.first_child;
				end
			end
			WS_EDGE: begin
				if (edge_hit) begin
					node_re    = 1'b1;
					node_raddr = child_idx;
				end else if (last_child) begin
					node_re    = 1'b1;
					node_raddr = miss_node;
				end else begin
					edge_re    = 1'b1;
					edge_raddr = next_child_idx;
				end
			end
			WS_FINAL: begin
				res.valid = node_rd.ends_keyword;
			end
			default: begin
				node_re = 1'b0;
			end
		endcase
	end

	// state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
			cur_q   <= '0;
			node_q  <= '0;
			ch_q    <= '0;
			k_q     <= '0;
			hops_q  <= '0;
		end else begin
			state_q <= state_d;
			if (scan_accept) begin
				node_q <= start_node;
				ch_q   <= cmd.req.text_byte;
				k_q    <= '0;
				hops_q <= '0;
			end else if (miss_now) begin
				node_q <= miss_node;
				k_q    <= '0;
				if (!miss_final) begin
					hops_q <= hops_q + HOP_W'(1);
				end
			end else if (state_q == WS_EDGE) begin
				if (edge_hit) begin
					node_q <= child_idx;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			if ((state_q == WS_FINAL) && final_done) begin
				cur_q <= node_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hops_q <= HOP_W'(NODES))
		else $error("failure hop count past budget");

	a_child_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WS_EDGE |-> k_q < node_rd.child_count)
		else $error("child search beyond child range");

	a_edge_after_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WS_EDGE |-> $past(state_q) == WS_NODE || $past(state_q) == WS_EDGE)
		else $error("edge compare without node load");

	a_start_at_root: assert property (@(posedge clk) disable iff (!arst_n)
		scan_accept && cmd.req.text_start |=> state_q == WS_NODE && node_q == '0)
		else $error("new text does not start at root");
`endif

endmodule

`default_nettype wire

FILE: rtl/multi_pattern_byte_matcher_unit.sv
// Aho-Corasick scanning engine, top level
//
// The cmd channel takes one request per handshake: opcode 0 loads one trie
// node (edge byte, child range, failure link, keyword id); opcode 1 scans
// one text byte. Every node that a scan can reach must be loaded first,
// node memories hold no reset value.
// A scan loads the current node, then for each node visited compares its
// children one by one, then loads the node reached. At worst the walk
// visits up to 4097 nodes on the failure chain and compares the children
// of each. The edge byte memory read port, one child per cycle, bounds the
// child search. A new request is taken once the walk of the last one ends.
// When the node reached ends a keyword, its id goes into an output register
// on the result channel. If the receiver stalls, that register holds, new
// requests are still taken, and a walk that ends on a keyword waits at its
// end until the register frees. Reset returns the walk to the root and
// empties the output register; the node memories keep their contents.
`default_nettype none

module multi_pattern_byte_matcher_unit import mpbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mpbm_cmd_if.sink    cmd,
	mpbm_res_if.source  result
);

	logic              node_we;
	logic [NODE_W-1:0] node_waddr;
	node_entry_t       node_wdata;
	logic              node_re;
	logic [NODE_W-1:0] node_raddr;
	node_entry_t       node_rd;
	logic              edge_we;
	logic [NODE_W-1:0] edge_waddr;
	logic [CHAR_W-1:0] edge_wdata;
	logic              edge_re;
	logic [NODE_W-1:0] edge_raddr;
	logic [CHAR_W-1:0] edge_rd;
	walk_res_t         res;
	logic              res_ready;
	logic              res_take;
	logic              out_valid_q;
	logic [KW_W-1:0]   out_kw_q;

	// node entries
	mpbm_ram #(
		.WIDTH($bits(node_entry_t)),
		.DEPTH(NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	// edge bytes, read by child index during the search
	mpbm_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(NODES)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.re    (edge_re),
		.raddr (edge_raddr),
		.rdata (edge_rd)
	);

	mpbm_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.node_we    (node_we),
		.node_waddr (node_waddr),
		.node_wdata (node_wdata),
		.node_re    (node_re),
		.node_raddr (node_raddr),
		.node_rd    (node_rd),
		.edge_we    (edge_we),
		.edge_waddr (edge_waddr),
		.edge_wdata (edge_wdata),
		.edge_re    (edge_re),
		.edge_raddr (edge_raddr),
		.edge_rd    (edge_rd),
		.res        (res),
		.res_ready  (res_ready)
	);

	// output register
	assign res_ready = !out_valid_q || result.ready;
	assign res_take  = res.valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_kw_q <= res.keyword;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.req.matched_keyword = out_kw_q;

`ifndef SYNTHESIS
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> result.valid && result.req.matched_keyword == $past(res.keyword))
		else $error("keyword id lost on the way out");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result request dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(result.req.matched_keyword))
		else $error("result payload changed while stalled");
`endif

endmodule

`default_nettype wire
